// ----- hw/rtl/sbt_pkg.sv -----
// Shared types, character codes, token codes and helpers for the S-expression byte tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package sbt_pkg;

	localparam int POS_BITS = 16;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

	// One input beat: a source byte, or the end-of-input marker.
	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_mark;
	} in_t;

	// One result beat.
	typedef struct packed {
		logic [3:0]          token_kind;
		logic [7:0]          text_byte;
		logic signed [63:0]  number_value;
		logic [2:0]          error_code;
		logic [POS_BITS-1:0] start_line;
		logic [POS_BITS-1:0] start_column;
		logic                last_of_run;
	} out_t;

	typedef enum logic [2:0] {
		MODE_BETWEEN,
		MODE_COMMENT,
		MODE_SIGN,
		MODE_NUMBER,
		MODE_STRING,
		MODE_SYMBOL,
		MODE_ERROR
	} mode_t;

	localparam logic [3:0] KIND_LPAREN  = 4'd0;
	localparam logic [3:0] KIND_RPAREN  = 4'd1;
	localparam logic [3:0] KIND_NUMBER  = 4'd2;
	localparam logic [3:0] KIND_STRBYTE = 4'd3;
	localparam logic [3:0] KIND_STREND  = 4'd4;
	localparam logic [3:0] KIND_SYMBYTE = 4'd5;
	localparam logic [3:0] KIND_SYMEND  = 4'd6;
	localparam logic [3:0] KIND_EOF     = 4'd7;
	localparam logic [3:0] KIND_ERROR   = 4'd8;

	localparam logic [2:0] ERR_OVERFLOW    = 3'd0;
	localparam logic [2:0] ERR_BAD_CHAR    = 3'd1;
	localparam logic [2:0] ERR_NL_IN_STR   = 3'd2;
	localparam logic [2:0] ERR_END_IN_STR  = 3'd3;
	localparam logic [2:0] ERR_STRAY_DELIM = 3'd4;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	localparam logic [7:0] COMMENT_START_RESET = CH_SEMI;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
			(c == CH_FF) || (c == CH_VT);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_SEMI) ||
			(c == CH_QUOTE) || is_space(c);
	endfunction

	function automatic out_t mk_res(input logic [3:0] kind, input logic [7:0] text,
		input logic [63:0] num, input logic [2:0] err,
		input logic [POS_BITS-1:0] line, input logic [POS_BITS-1:0] col);
		out_t r;
		r.token_kind   = kind;
		r.text_byte    = text;
		r.number_value = num;
		r.error_code   = err;
		r.start_line   = line;
		r.start_column = col;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sexpr_byte_tokenizer.sv -----
// Streaming S-expression tokenizer: per-byte scanner with a three-slot result buffer.
//
// Usage: source text enters on the in channel (valid/ready), one byte per beat, or an
// end-of-input beat with end_mark set. Tokens leave on the out channel, one per beat:
// parentheses, numbers, string and symbol text bytes with their end tokens, end of
// input and errors, each stamped with the line and column where the token began.
// One input beat yields zero to three result beats; last_of_run flags the final one.
// The user writes the comment start byte via cfg_we/cfg_wdata only while idle; not enforced.
//
// Results of a byte are registered and visible on the out channel the cycle after it is
// accepted. Throughput: one input beat per cycle while each beat gives at most one
// result and the receiver keeps up; a beat giving more results holds the input until
// the three-slot result buffer is down to its last result and that one is taken.
// When the receiver stalls, the current result holds steady and input stalls once
// the buffer cannot be emptied in the same cycle.
// Reset clears the scanner to "between tokens" at line 1, column 1, empties the
// buffer and restores the comment start byte to ';'. The end-of-input beat also
// returns the scanner to that state, keeping the comment start byte.
`timescale 1ns / 1ps
`default_nettype none

module sexpr_byte_tokenizer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire sbt_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output sbt_pkg::out_t      out_data,
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_wdata
);
	import sbt_pkg::*;

	// Scanner state.
	mode_t               mode_q, mode_d;
	logic                esc_q, esc_d;
	logic                neg_q, neg_d;
	logic [63:0]         acc_q, acc_d;
	logic [POS_BITS-1:0] cur_line_q, cur_line_d, cur_col_q, cur_col_d;
	logic [POS_BITS-1:0] tok_line_q, tok_line_d, tok_col_q, tok_col_d;
	logic [7:0]          comment_q;

	// Result buffer: slot 0 is the one on the out channel.
	out_t                slot_q [3];
	logic [1:0]          cnt_q;

	out_t                res_d [3];
	logic [1:0]          n_d;

	logic                accept, pop;
	logic [7:0]          c;
	logic [3:0]          dig;
	logic [7:0]          sign_byte;
	logic [63:0]         num_val;
	logic [67:0]         next_acc, lim;
	logic                ovf;

	// Outcome of opening a new token on the current byte.
	logic                st_emit, st_tok;
	mode_t               st_mode;
	out_t                st_res;
	logic                do_start;

	assign c         = in_data.source_byte;
	assign dig       = 4'(c - CH_ZERO);
	assign sign_byte = neg_q ? CH_MINUS : CH_PLUS;
	assign num_val   = neg_q ? (64'd0 - acc_q) : acc_q;

	// accum*10 + digit, checked against the signed limit for the pending sign.
	assign next_acc = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, dig};
	assign lim      = neg_q ? {4'd0, 1'b1, 63'd0} : {5'd0, {63{1'b1}}};
	assign ovf      = next_acc > lim;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[0];
	assign pop       = out_valid && out_ready;
	assign in_ready  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign accept    = in_valid && in_ready;

	always_comb begin
		st_emit = 1'b0;
		st_tok  = 1'b1;
		st_mode = MODE_BETWEEN;
		st_res  = mk_res(KIND_LPAREN, 8'd0, 64'd0, 3'd0, cur_line_q, cur_col_q);
		if (is_space(c)) begin
			st_tok = 1'b0;
		end else if (c == comment_q) begin
			st_tok  = 1'b0;
			st_mode = MODE_COMMENT;
		end else if (c == CH_LPAREN) begin
			st_emit = 1'b1;
		end else if (c == CH_RPAREN) begin
			st_emit = 1'b1;
			st_res  = mk_res(KIND_RPAREN, 8'd0, 64'd0, 3'd0, cur_line_q, cur_col_q);
		end else if (c == CH_QUOTE) begin
			st_mode = MODE_STRING;
		end else if (is_digit(c)) begin
			st_mode = MODE_NUMBER;
		end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
			st_mode = MODE_SIGN;
		end else if (is_delim(c)) begin
			st_emit = 1'b1;
			st_mode = MODE_ERROR;
			st_res  = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_STRAY_DELIM, cur_line_q, cur_col_q);
		end else begin
			st_emit = 1'b1;
			st_mode = MODE_SYMBOL;
			st_res  = mk_res(KIND_SYMBYTE, c, 64'd0, 3'd0, cur_line_q, cur_col_q);
		end
	end

	always_comb begin
		mode_d     = mode_q;
		esc_d      = esc_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		cur_line_d = cur_line_q;
		cur_col_d  = cur_col_q;
		tok_line_d = tok_line_q;
		tok_col_d  = tok_col_q;
		do_start   = 1'b0;
		n_d        = 2'd0;
		for (int i = 0; i < 3; i++) begin
			res_d[i] = '0;
		end

		if (in_data.end_mark) begin
			case (mode_q)
				MODE_SIGN: begin
					res_d[n_d] = mk_res(KIND_SYMBYTE, sign_byte, 64'd0, 3'd0,
						tok_line_q, tok_col_q);
					n_d = n_d + 2'd1;
					res_d[n_d] = mk_res(KIND_SYMEND, 8'd0, 64'd0, 3'd0, tok_line_q, tok_col_q);
					n_d = n_d + 2'd1;
				end
				MODE_NUMBER: begin
					res_d[n_d] = mk_res(KIND_NUMBER, 8'd0, num_val, 3'd0, tok_line_q, tok_col_q);
					n_d = n_d + 2'd1;
				end
				MODE_SYMBOL: begin
					res_d[n_d] = mk_res(KIND_SYMEND, 8'd0, 64'd0, 3'd0, tok_line_q, tok_col_q);
					n_d = n_d + 2'd1;
				end
				MODE_STRING: begin
					res_d[n_d] = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_END_IN_STR,
						tok_line_q, tok_col_q);
					n_d = n_d + 2'd1;
				end
				default: begin
				end
			endcase
			// An open string or an earlier error closes the stream without an eof token.
			if ((mode_q != MODE_ERROR) && (mode_q != MODE_STRING)) begin
				res_d[n_d] = mk_res(KIND_EOF, 8'd0, 64'd0, 3'd0, cur_line_q, cur_col_q);
				n_d = n_d + 2'd1;
			end
			mode_d     = MODE_BETWEEN;
			esc_d      = 1'b0;
			neg_d      = 1'b0;
			acc_d      = 64'd0;
			cur_line_d = POS_ONE;
			cur_col_d  = POS_ONE;
			tok_line_d = POS_ONE;
			tok_col_d  = POS_ONE;
		end else begin
			case (mode_q)
				MODE_BETWEEN: begin
					do_start = 1'b1;
				end
				MODE_COMMENT: begin
					if (c == CH_LF) begin
						mode_d = MODE_BETWEEN;
					end
				end
				MODE_SIGN: begin
					if (is_digit(c)) begin
						mode_d = MODE_NUMBER;
						acc_d  = {60'd0, dig};
					end else begin
						// A sign with no digit behind it is the first byte of a symbol.
						res_d[n_d] = mk_res(KIND_SYMBYTE, sign_byte, 64'd0, 3'd0,
							tok_line_q, tok_col_q);
						n_d = n_d + 2'd1;
						if (is_delim(c)) begin
							res_d[n_d] = mk_res(KIND_SYMEND, 8'd0, 64'd0, 3'd0,
								tok_line_q, tok_col_q);
							n_d = n_d + 2'd1;
							do_start = 1'b1;
						end else begin
							mode_d = MODE_SYMBOL;
							res_d[n_d] = mk_res(KIND_SYMBYTE, c, 64'd0, 3'd0,
								tok_line_q, tok_col_q);
							n_d = n_d + 2'd1;
						end
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c)) begin
						if (ovf) begin
							mode_d = MODE_ERROR;
							res_d[n_d] = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_OVERFLOW,
								tok_line_q, tok_col_q);
							n_d = n_d + 2'd1;
						end else begin
							acc_d = next_acc[63:0];
						end
					end else if (is_delim(c)) begin
						res_d[n_d] = mk_res(KIND_NUMBER, 8'd0, num_val, 3'd0,
							tok_line_q, tok_col_q);
						n_d = n_d + 2'd1;
						do_start = 1'b1;
					end else begin
						mode_d = MODE_ERROR;
						res_d[n_d] = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_BAD_CHAR,
							tok_line_q, tok_col_q);
						n_d = n_d + 2'd1;
					end
				end
				MODE_STRING: begin
					if (esc_q) begin
						esc_d = 1'b0;
						res_d[n_d] = mk_res(KIND_STRBYTE,
							(c == CH_LOW_N) ? CH_LF :
							(c == CH_LOW_R) ? CH_CR :
							(c == CH_LOW_T) ? CH_TAB : c,
							64'd0, 3'd0, tok_line_q, tok_col_q);
						n_d = n_d + 2'd1;
					end else if (c == CH_QUOTE) begin
						mode_d = MODE_BETWEEN;
						res_d[n_d] = mk_res(KIND_STREND, 8'd0, 64'd0, 3'd0,
							tok_line_q, tok_col_q);
						n_d = n_d + 2'd1;
					end else if (c == CH_LF) begin
						mode_d = MODE_ERROR;
						res_d[n_d] = mk_res(KIND_ERROR, 8'd0, 64'd0, ERR_NL_IN_STR,
							tok_line_q, tok_col_q);
						n_d = n_d + 2'd1;
					end else if (c == CH_BSLASH) begin
						esc_d = 1'b1;
					end else begin
						res_d[n_d] = mk_res(KIND_STRBYTE, c, 64'd0, 3'd0,
							tok_line_q, tok_col_q);
						n_d = n_d + 2'd1;
					end
				end
				MODE_SYMBOL: begin
					if (is_delim(c)) begin
						res_d[n_d] = mk_res(KIND_SYMEND, 8'd0, 64'd0, 3'd0,
							tok_line_q, tok_col_q);
						n_d = n_d + 2'd1;
						do_start = 1'b1;
					end else begin
						res_d[n_d] = mk_res(KIND_SYMBYTE, c, 64'd0, 3'd0,
							tok_line_q, tok_col_q);
						n_d = n_d + 2'd1;
					end
				end
				default: begin
					// Error state swallows everything up to the end marker.
					mode_d = MODE_ERROR;
				end
			endcase

			// A byte between tokens, or the delimiter that closed a token, may open the next one.
			if (do_start) begin
				mode_d = st_mode;
				if (st_emit) begin
					res_d[n_d] = st_res;
					n_d = n_d + 2'd1;
				end
				if (st_tok) begin
					tok_line_d = cur_line_q;
					tok_col_d  = cur_col_q;
				end
				if (st_mode == MODE_STRING) begin
					esc_d = 1'b0;
				end
				if (st_mode == MODE_NUMBER) begin
					neg_d = 1'b0;
					acc_d = {60'd0, dig};
				end
				if (st_mode == MODE_SIGN) begin
					neg_d = (c == CH_MINUS);
					acc_d = 64'd0;
				end
			end

			// Source position, saturating.
			if (c == CH_LF) begin
				if (cur_line_q != POS_MAX) begin
					cur_line_d = cur_line_q + POS_ONE;
				end
				cur_col_d = POS_ONE;
			end else if (cur_col_q != POS_MAX) begin
				cur_col_d = cur_col_q + POS_ONE;
			end
		end

		if (n_d != 2'd0) begin
			res_d[n_d - 2'd1].last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_BETWEEN;
			esc_q      <= 1'b0;
			neg_q      <= 1'b0;
			acc_q      <= 64'd0;
			cur_line_q <= POS_ONE;
			cur_col_q  <= POS_ONE;
			tok_line_q <= POS_ONE;
			tok_col_q  <= POS_ONE;
			comment_q  <= COMMENT_START_RESET;
			cnt_q      <= 2'd0;
		end else begin
			if (cfg_we) begin
				comment_q <= cfg_wdata;
			end
			if (accept) begin
				mode_q     <= mode_d;
				esc_q      <= esc_d;
				neg_q      <= neg_d;
				acc_q      <= acc_d;
				cur_line_q <= cur_line_d;
				cur_col_q  <= cur_col_d;
				tok_line_q <= tok_line_d;
				tok_col_q  <= tok_col_d;
				cnt_q      <= n_d;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Buffer payload: loaded whole on an accepted beat, shifted down on each taken result.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[0] <= res_d[0];
			slot_q[1] <= res_d[1];
			slot_q[2] <= res_d[2];
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sbt_checker.sv -----
// Port-level assertions for the tokenizer, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module sbt_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire sbt_pkg::in_t  in_data,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire sbt_pkg::out_t out_data,
	input wire logic          cfg_we,
	input wire logic [7:0]    cfg_wdata
);
	import sbt_pkg::*;

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// Results only appear after an input beat has been taken.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result beat without an accepted input beat");

	// End of input and errors always close their run.
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_data.token_kind == KIND_EOF) ||
		(out_data.token_kind == KIND_ERROR)) |-> out_data.last_of_run)
		else $error("eof or error token not last of its run");

	// Non-error tokens carry an error code of zero.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.token_kind != KIND_ERROR) |-> (out_data.error_code == 3'd0))
		else $error("error code on a non-error token");

endmodule

bind sexpr_byte_tokenizer sbt_checker u_sbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata)
);

`default_nettype wire
